[rtl/tct_pkg.sv]
// Package for the touch contact tracker: field widths, the event kind and
// sequencer state types, the slot record and the divider status struct.
// Used by the divider, the tracker and the testbench; depends on nothing else.
`default_nettype none

package tct_pkg;

    localparam int ID_W    = 64;
    localparam int POS_W   = 16;
    localparam int TIME_W  = 48;
    localparam int DUR_W   = 39;
    localparam int COUNT_W = 32;

    localparam int NUM_SLOTS_DEF    = 16;
    localparam int TICKS_PER_MS_DEF = 1000;

    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_MOVE  = 2'd1,
        KIND_UP    = 2'd2,
        KIND_OTHER = 2'd3
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_DIVIDE,
        ST_EMIT
    } tct_state_t;

    typedef struct packed {
        logic [ID_W-1:0]          owner;
        logic signed [POS_W-1:0]  start_x;
        logic signed [POS_W-1:0]  start_y;
        logic [TIME_W-1:0]        start_time;
        logic [COUNT_W-1:0]       count;
    } slot_rec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tct_div_stat_t;

endpackage

`default_nettype wire

[rtl/tct_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Holds the per-slot contact records; depends on nothing else.
`default_nettype none

module tct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/tct_div.sv]
// Constant divider by reciprocal multiplication: one shared multiplier adds
// four partial products into an accumulator in turn.
// Turns elapsed ticks into milliseconds; depends on tct_pkg.
`default_nettype none

module tct_div
    import tct_pkg::*;
#(
    parameter int DIVISOR = TICKS_PER_MS_DEF,
    parameter int DW      = TIME_W
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    output logic      [DW-1:0] quotient,
    output tct_div_stat_t      stat
);

    localparam int L     = $clog2(DIVISOR);
    localparam int SHIFT = DW + L;
    localparam int MW    = DW + 1;
    localparam int PW    = 2 * DW + L + 2;
    localparam int NLW   = DW / 2;
    localparam int NHW   = DW - NLW;
    localparam int MLW   = (MW + 1) / 2;
    localparam logic [127:0] MAGIC_WIDE =
        ((128'd1 << SHIFT) + 128'(DIVISOR - 1)) / 128'(DIVISOR);
    localparam logic [MW-1:0] MAGIC = MAGIC_WIDE[MW-1:0];

    logic [DW-1:0]      num_reg, num_next;
    logic [PW-1:0]      acc_reg, acc_next;
    logic [1:0]         step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [NHW-1:0]     mul_a;
    logic [MLW-1:0]     mul_b;
    logic [NHW+MLW-1:0] prod;
    logic [PW-1:0]      part;

    assign mul_a = step_reg[1] ? num_reg[DW-1:NLW] : NHW'(num_reg[NLW-1:0]);
    assign mul_b = step_reg[0] ? MLW'(MAGIC[MW-1:MLW]) : MAGIC[MLW-1:0];
    assign prod  = mul_a * mul_b;

    always_comb
    begin
        unique case (step_reg)
            2'd0:
            begin
                part = PW'(prod);
            end
            2'd1:
            begin
                part = PW'(prod) << MLW;
            end
            2'd2:
            begin
                part = PW'(prod) << NLW;
            end
            2'd3:
            begin
                part = PW'(prod) << (NLW + MLW);
            end
        endcase
    end

    always_comb
    begin
        num_next  = num_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + part;
            step_next = step_reg + 1'b1;
            if (step_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        acc_reg <= acc_next;
    end

    assign quotient  = acc_reg[SHIFT +: DW];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[rtl/touch_contact_tracker.sv]
// Touch contact tracker: an event is taken while the block is idle, then the
// slot table is scanned one slot per cycle through the single read port of the
// slot memory, and an up event then runs through the four-step reciprocal
// multiplier that turns ticks into milliseconds. An event of the ignored kind
// is taken while idle and leaves the block idle.
// A finished summary waits in the output register while the next event runs;
// an up event that finishes while that register is still held waits in its
// emit step, with the input stalled, until the register is taken.
`default_nettype none

module touch_contact_tracker
    import tct_pkg::*;
#(
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF,
    parameter int TICKS_PER_MS = TICKS_PER_MS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     evt_valid,
    output logic                          evt_stall,
    input  wire logic [1:0]               req_type,
    input  wire logic [ID_W-1:0]          contact_id,
    input  wire logic signed [POS_W-1:0]  pos_x,
    input  wire logic signed [POS_W-1:0]  pos_y,
    input  wire logic [TIME_W-1:0]        timestamp,
    output logic                          sum_valid,
    input  wire logic                     sum_stall,
    output logic [ID_W-1:0]               done_id,
    output logic signed [POS_W-1:0]       first_x,
    output logic signed [POS_W-1:0]       first_y,
    output logic signed [POS_W-1:0]       last_x,
    output logic signed [POS_W-1:0]       last_y,
    output logic [DUR_W-1:0]              elapsed_ms,
    output logic [COUNT_W-1:0]            samples
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);

    tct_state_t state_reg, state_next;

    logic [NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic                 found_reg, found_next;
    logic                 free_found_reg, free_found_next;
    logic [IW-1:0]        match_slot_reg, match_slot_next;
    logic [IW-1:0]        free_slot_reg, free_slot_next;
    logic                 sum_valid_reg, sum_valid_next;

    req_kind_t               kind_reg, kind_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic signed [POS_W-1:0] x_reg, x_next;
    logic signed [POS_W-1:0] y_reg, y_next;
    logic [TIME_W-1:0]       t_reg, t_next;
    logic signed [POS_W-1:0] hold_x_reg, hold_x_next;
    logic signed [POS_W-1:0] hold_y_reg, hold_y_next;
    logic [TIME_W-1:0]       hold_t_reg, hold_t_next;
    logic [COUNT_W-1:0]      hold_cnt_reg, hold_cnt_next;

    logic [ID_W-1:0]         out_id_reg, out_id_next;
    logic signed [POS_W-1:0] out_fx_reg, out_fx_next;
    logic signed [POS_W-1:0] out_fy_reg, out_fy_next;
    logic signed [POS_W-1:0] out_lx_reg, out_lx_next;
    logic signed [POS_W-1:0] out_ly_reg, out_ly_next;
    logic [DUR_W-1:0]        out_dur_reg, out_dur_next;
    logic [COUNT_W-1:0]      out_cnt_reg, out_cnt_next;

    slot_rec_t     rd_rec;
    slot_rec_t     wr_rec;
    logic          ram_we;
    logic [IW-1:0] slot_sel;
    logic          accept;
    logic          issue;
    logic          hit;
    logic          last_cmp;
    logic          restart;
    logic          drop;
    logic          is_up;
    logic          out_free;
    logic          div_start;
    logic [TIME_W-1:0]  t_sel;
    logic [TIME_W:0]    t_diff;
    logic [TIME_W-1:0]  elapsed;
    logic [COUNT_W-1:0] cnt_base;
    logic [COUNT_W-1:0] cnt_new;
    logic [TIME_W-1:0]  quotient;
    logic [DUR_W-1:0]   dur_sat;
    tct_div_stat_t      div_stat;

    assign accept   = evt_valid && !evt_stall;
    assign issue    = (idx_reg < CW'(NUM_SLOTS));
    assign hit      = rd_pend_reg && busy_reg[cmp_idx_reg] && (rd_rec.owner == id_reg);
    assign last_cmp = rd_pend_reg && (cmp_idx_reg == IW'(NUM_SLOTS - 1));
    assign is_up    = (kind_reg == KIND_UP);
    assign restart  = (kind_reg == KIND_DOWN) || !found_reg;
    assign drop     = !found_reg && !free_found_reg;
    assign slot_sel = found_reg ? match_slot_reg : free_slot_reg;
    assign out_free = !sum_valid_reg || !sum_stall;

    assign t_sel    = restart ? t_reg : hold_t_reg;
    assign t_diff   = {1'b0, t_reg} - {1'b0, t_sel};
    assign elapsed  = t_diff[TIME_W] ? '0 : t_diff[TIME_W-1:0];
    assign cnt_base = restart ? '0 : hold_cnt_reg;
    assign cnt_new  = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
    assign dur_sat  = (|quotient[TIME_W-1:DUR_W]) ? '1 : quotient[DUR_W-1:0];

    assign wr_rec.owner      = id_reg;
    assign wr_rec.start_x    = restart ? x_reg : hold_x_reg;
    assign wr_rec.start_y    = restart ? y_reg : hold_y_reg;
    assign wr_rec.start_time = t_sel;
    assign wr_rec.count      = cnt_new;

    assign ram_we    = (state_reg == ST_DECIDE) && !drop && !is_up;
    assign div_start = (state_reg == ST_DECIDE) && !drop && is_up;

    tct_ram #(
        .WIDTH ($bits(slot_rec_t)),
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_sel),
        .wdata (wr_rec),
        .raddr (idx_reg[IW-1:0]),
        .rdata (rd_rec)
    );

    tct_div #(
        .DIVISOR (TICKS_PER_MS),
        .DW      (TIME_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (elapsed),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_kind_t'(req_type) != KIND_OTHER))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_cmp)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = (!drop && is_up) ? ST_DIVIDE : ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy_next       = busy_reg;
        idx_next        = idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        rd_pend_next    = 1'b0;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        match_slot_next = match_slot_reg;
        free_slot_next  = free_slot_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        t_next          = t_reg;
        hold_x_next     = hold_x_reg;
        hold_y_next     = hold_y_reg;
        hold_t_next     = hold_t_reg;
        hold_cnt_next   = hold_cnt_reg;
        out_id_next     = out_id_reg;
        out_fx_next     = out_fx_reg;
        out_fy_next     = out_fy_reg;
        out_lx_next     = out_lx_reg;
        out_ly_next     = out_ly_reg;
        out_dur_next    = out_dur_reg;
        out_cnt_next    = out_cnt_reg;
        sum_valid_next  = sum_valid_reg && sum_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                evt_stall       = 1'b0;
                idx_next        = '0;
                found_next      = 1'b0;
                free_found_next = 1'b0;
                if (accept)
                begin
                    kind_next = req_kind_t'(req_type);
                    id_next   = contact_id;
                    x_next    = pos_x;
                    y_next    = pos_y;
                    t_next    = timestamp;
                end
            end
            ST_SCAN:
            begin
                evt_stall = 1'b1;
                if (issue)
                begin
                    idx_next     = idx_reg + 1'b1;
                    cmp_idx_next = idx_reg[IW-1:0];
                    rd_pend_next = 1'b1;
                end
                if (hit && !found_reg)
                begin
                    found_next      = 1'b1;
                    match_slot_next = cmp_idx_reg;
                    hold_x_next     = rd_rec.start_x;
                    hold_y_next     = rd_rec.start_y;
                    hold_t_next     = rd_rec.start_time;
                    hold_cnt_next   = rd_rec.count;
                end
                if (rd_pend_reg && !busy_reg[cmp_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_slot_next  = cmp_idx_reg;
                end
            end
            ST_DECIDE:
            begin
                evt_stall = 1'b1;
                if (!drop)
                begin
                    busy_next[slot_sel] = !is_up;
                    hold_x_next         = wr_rec.start_x;
                    hold_y_next         = wr_rec.start_y;
                    hold_cnt_next       = cnt_new;
                end
            end
            ST_DIVIDE:
            begin
                evt_stall = 1'b1;
            end
            ST_EMIT:
            begin
                evt_stall = 1'b1;
                if (out_free)
                begin
                    sum_valid_next = 1'b1;
                    out_id_next    = id_reg;
                    out_fx_next    = hold_x_reg;
                    out_fy_next    = hold_y_reg;
                    out_lx_next    = x_reg;
                    out_ly_next    = y_reg;
                    out_dur_next   = dur_sat;
                    out_cnt_next   = hold_cnt_reg;
                end
            end
            default:
            begin
                evt_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            busy_reg       <= '0;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            idx_reg        <= idx_next;
            rd_pend_reg    <= rd_pend_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            sum_valid_reg  <= sum_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        t_reg          <= t_next;
        hold_x_reg     <= hold_x_next;
        hold_y_reg     <= hold_y_next;
        hold_t_reg     <= hold_t_next;
        hold_cnt_reg   <= hold_cnt_next;
        out_id_reg     <= out_id_next;
        out_fx_reg     <= out_fx_next;
        out_fy_reg     <= out_fy_next;
        out_lx_reg     <= out_lx_next;
        out_ly_reg     <= out_ly_next;
        out_dur_reg    <= out_dur_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign sum_valid  = sum_valid_reg;
    assign done_id    = out_id_reg;
    assign first_x    = out_fx_reg;
    assign first_y    = out_fy_reg;
    assign last_x     = out_lx_reg;
    assign last_y     = out_ly_reg;
    assign elapsed_ms = out_dur_reg;
    assign samples    = out_cnt_reg;

    // A new summary can only come out of the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sum_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("summary raised outside the emit step");

    // The divider runs and finishes only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_stat.busy || div_stat.done) |-> (state_reg == ST_DIVIDE))
        else $error("divider active outside the divide step");

    // Slot occupancy changes only as the result of a decision.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(busy_reg) |-> $past(state_reg == ST_DECIDE))
        else $error("slot busy bits changed outside the decide step");

endmodule

`default_nettype wire

[dv/touch_contact_tracker_test.sv]
// Self-checking testbench for the touch contact tracker: directed gestures,
// full-table drops, output backpressure and long random event traffic.
// Depends on tct_pkg and touch_contact_tracker from the rtl folder.
`default_nettype none

module touch_contact_tracker_test;
    import tct_pkg::*;

    localparam int HOLD_CYCLES   = 500;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [TIME_W-1:0] DUR_MAX  = (48'd1 << DUR_W) - 48'd1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic [DUR_W-1:0]        dur;
        logic [COUNT_W-1:0]      count;
    } summary_t;

    logic                    clk;
    logic                    rst_n;
    logic                    evt_valid;
    logic                    evt_stall;
    logic [1:0]              req_type;
    logic [ID_W-1:0]         contact_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [TIME_W-1:0]       timestamp;
    logic                    sum_valid;
    logic                    sum_stall;
    logic [ID_W-1:0]         done_id;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] last_x;
    logic signed [POS_W-1:0] last_y;
    logic [DUR_W-1:0]        elapsed_ms;
    logic [COUNT_W-1:0]      samples;

    logic                    tracked_busy  [NUM_SLOTS_DEF];
    logic [ID_W-1:0]         tracked_owner [NUM_SLOTS_DEF];
    logic signed [POS_W-1:0] tracked_x0    [NUM_SLOTS_DEF];
    logic signed [POS_W-1:0] tracked_y0    [NUM_SLOTS_DEF];
    logic [TIME_W-1:0]       tracked_t0    [NUM_SLOTS_DEF];
    logic [COUNT_W-1:0]      tracked_count [NUM_SLOTS_DEF];

    summary_t          pending_summaries[$];
    int                mismatch_count;
    int                gap_max;
    int                stall_max;
    bit                hold_request;
    logic              hold_on;
    logic [TIME_W-1:0] event_clock;

    touch_contact_tracker uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .req_type   (req_type),
        .contact_id (contact_id),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .timestamp  (timestamp),
        .sum_valid  (sum_valid),
        .sum_stall  (sum_stall),
        .done_id    (done_id),
        .first_x    (first_x),
        .first_y    (first_y),
        .last_x     (last_x),
        .last_y     (last_y),
        .elapsed_ms (elapsed_ms),
        .samples    (samples)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 200)
        begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    // Updates the contact table for one item and returns 1 when the item
    // closes a contact, with the summary that the block should emit.
    function automatic bit advance_contacts(input req_kind_t kind,
            input logic [ID_W-1:0] id, input logic signed [POS_W-1:0] x,
            input logic signed [POS_W-1:0] y, input logic [TIME_W-1:0] t,
            output summary_t summary);
        int slot;
        logic [TIME_W-1:0] ms;
        summary = '0;
        if (kind == KIND_OTHER)
        begin
            return 1'b0;
        end
        slot = -1;
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
        begin
            if (slot < 0 && tracked_busy[i] && tracked_owner[i] == id)
            begin
                slot = i;
            end
        end
        if (kind == KIND_DOWN || slot < 0)
        begin
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
            begin
                if (slot < 0 && !tracked_busy[i])
                begin
                    slot = i;
                end
            end
            if (slot < 0)
            begin
                return 1'b0;
            end
            tracked_busy[slot]  = 1'b1;
            tracked_owner[slot] = id;
            tracked_x0[slot]    = x;
            tracked_y0[slot]    = y;
            tracked_t0[slot]    = t;
            tracked_count[slot] = '0;
        end
        if (tracked_count[slot] != '1)
        begin
            tracked_count[slot]++;
        end
        if (kind != KIND_UP)
        begin
            return 1'b0;
        end
        ms = (t >= tracked_t0[slot]) ? (t - tracked_t0[slot]) / TICKS_PER_MS_DEF : '0;
        if (ms > DUR_MAX)
        begin
            ms = DUR_MAX;
        end
        summary.id      = id;
        summary.start_x = tracked_x0[slot];
        summary.start_y = tracked_y0[slot];
        summary.end_x   = x;
        summary.end_y   = y;
        summary.dur     = ms[DUR_W-1:0];
        summary.count   = tracked_count[slot];
        tracked_busy[slot] = 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [ID_W-1:0] fresh_contact_id();
        if ($urandom_range(0, 9) == 0)
        begin
            return ID_W'($urandom_range(0, 7));
        end
        return {$urandom, $urandom};
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_event(input req_kind_t kind, input logic [ID_W-1:0] id,
                              input logic signed [POS_W-1:0] x,
                              input logic signed [POS_W-1:0] y,
                              input logic [TIME_W-1:0] t);
        int gap;
        summary_t summary;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            evt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type   <= kind;
        contact_id <= id;
        pos_x      <= x;
        pos_y      <= y;
        timestamp  <= t;
        evt_valid  <= 1'b1;
        do @(posedge clk); while (evt_stall);
        if (advance_contacts(kind, id, x, y, t, summary))
        begin
            pending_summaries.push_back(summary);
        end
    endtask

    task automatic wait_drained();
        evt_valid <= 1'b0;
        while (pending_summaries.size() != 0) @(posedge clk);
    endtask

    task automatic test_ignored_kind();
        send_event(KIND_OTHER, '1, 16'sh7fff, -16'sd32768, TIME_MAX);
        wait_drained();
    endtask

    task automatic test_unmatched_up();
        // Id zero matches the cleared owner field, but no slot is busy yet.
        send_event(KIND_UP, '0, -16'sd32768, 16'sh7fff, TIME_MAX);
        wait_drained();
    endtask

    task automatic test_full_gesture();
        send_event(KIND_DOWN, '1, -16'sd32768, -16'sd32768, '0);
        send_event(KIND_MOVE, '1, 16'sh7fff, 16'sh7fff, 48'd12345);
        send_event(KIND_UP, '1, 16'sd0, -16'sd1, TIME_MAX);
        wait_drained();
    endtask

    task automatic test_time_backwards();
        send_event(KIND_DOWN, 64'h8000_0000_0000_0001, 16'sd100, 16'sd200, 48'd5_000_000);
        send_event(KIND_UP, 64'h8000_0000_0000_0001, 16'sd101, 16'sd201, 48'd1000);
        wait_drained();
    endtask

    task automatic test_repeated_down();
        send_event(KIND_DOWN, 64'd5, 16'sd10, 16'sd10, 48'd100);
        send_event(KIND_DOWN, 64'd5, -16'sd20, 16'sd30, 48'd2_000_000);
        send_event(KIND_UP, 64'd5, 16'sd40, -16'sd50, 48'd3_500_000);
        wait_drained();
    endtask

    task automatic test_unmatched_move();
        send_event(KIND_MOVE, 64'h5555_aaaa_5555_aaaa, 16'sd7, -16'sd7, 48'd7_000_000);
        send_event(KIND_UP, 64'h5555_aaaa_5555_aaaa, 16'sd9, -16'sd9, 48'd7_999_999);
        wait_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
        begin
            send_event(KIND_DOWN, 64'h0123_4567_0000_0000 + ID_W'(i), POS_W'($urandom),
                       POS_W'($urandom), 48'd1_000_000 * TIME_W'(i));
        end
        // With every slot taken, new contacts of any kind are dropped.
        send_event(KIND_DOWN, 64'hfeed_0000_0000_0001, 16'sd1, 16'sd1, 48'd20_000_000);
        send_event(KIND_MOVE, 64'hfeed_0000_0000_0002, 16'sd2, 16'sd2, 48'd20_000_001);
        send_event(KIND_UP, 64'hfeed_0000_0000_0003, 16'sd3, 16'sd3, 48'd20_000_002);
        // Lifting every contact empties the table again.
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
        begin
            send_event(KIND_UP, 64'h0123_4567_0000_0000 + ID_W'(i), POS_W'($urandom),
                       POS_W'($urandom), 48'd20_000_100 + TIME_W'(i));
        end
        wait_drained();
        event_clock = 48'd21_000_000;
    endtask

    task automatic test_output_backpressure();
        logic [ID_W-1:0] id;
        gap_max = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            id = fresh_contact_id();
            event_clock += 48'd50_000;
            send_event(KIND_DOWN, id, POS_W'($urandom), POS_W'($urandom), event_clock);
            event_clock += 48'd70_000;
            send_event(KIND_UP, id, POS_W'($urandom), POS_W'($urandom), event_clock);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int next_chunk;
        int chunk;
        int roll;
        int down_pct;
        int busy_slots[$];
        req_kind_t kind;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] t;
        sent = 0;
        next_chunk = 0;
        chunk = 0;
        down_pct = 10;
        while (sent < n_items)
        begin
            if (sent >= next_chunk)
            begin
                if (chunk % 2 == 1)
                begin
                    wait_drained();
                end
                gap_max   = (chunk % 3 == 0) ? 0 : ((chunk % 3 == 1) ? 3 : 9);
                stall_max = (chunk % 4 == 0) ? 0 : 9;
                down_pct  = (chunk % 2 == 0) ? 45 : 10;
                chunk++;
                next_chunk += 200;
            end
            busy_slots.delete();
            for (int i = 0; i < NUM_SLOTS_DEF; i++)
            begin
                if (tracked_busy[i])
                begin
                    busy_slots.push_back(i);
                end
            end
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                kind = KIND_OTHER;
                id = fresh_contact_id();
            end
            else if (roll < 4 + down_pct)
            begin
                kind = KIND_DOWN;
                id = fresh_contact_id();
                if (busy_slots.size() != 0 && $urandom_range(0, 4) == 0)
                begin
                    id = tracked_owner[busy_slots[$urandom_range(0, busy_slots.size() - 1)]];
                end
            end
            else if (roll < 10 + down_pct)
            begin
                kind = $urandom_range(0, 1) ? KIND_UP : KIND_MOVE;
                id = fresh_contact_id();
            end
            else if (busy_slots.size() != 0)
            begin
                kind = ($urandom_range(0, 99) < 35) ? KIND_UP : KIND_MOVE;
                id = tracked_owner[busy_slots[$urandom_range(0, busy_slots.size() - 1)]];
            end
            else
            begin
                kind = KIND_DOWN;
                id = fresh_contact_id();
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                t = {16'($urandom), $urandom};
                event_clock = t;
            end
            else if (roll < 6)
            begin
                t = event_clock - TIME_W'($urandom_range(0, 1_000_000));
            end
            else
            begin
                event_clock += TIME_W'($urandom_range(0, 400_000));
                t = event_clock;
            end
            send_event(kind, id, POS_W'($urandom), POS_W'($urandom), t);
            if (kind != KIND_OTHER)
            begin
                sent++;
            end
        end
        wait_drained();
    endtask

    initial
    begin : output_hold
        int held;
        hold_on <= 1'b0;
        forever
        begin
            wait (hold_request);
            @(posedge clk);
            hold_on <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
            hold_on <= 1'b0;
            hold_request = 1'b0;
        end
    end

    initial
    begin : summary_receiver
        int pause;
        pause = 0;
        sum_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && sum_valid && !sum_stall)
            begin
                pause = $urandom_range(0, stall_max);
            end
            if (hold_on || pause > 0)
            begin
                sum_stall <= 1'b1;
                if (pause > 0)
                begin
                    pause--;
                end
            end
            else
            begin
                sum_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : summary_checker
        summary_t want;
        if (rst_n && sum_valid && !sum_stall)
        begin
            if (pending_summaries.size() == 0)
            begin
                report_mismatch($sformatf("summary for id %h with none pending", done_id));
            end
            else
            begin
                want = pending_summaries.pop_front();
                check_field("done_id", done_id, want.id);
                check_field("first_x", first_x, want.start_x);
                check_field("first_y", first_y, want.start_y);
                check_field("last_x", last_x, want.end_x);
                check_field("last_y", last_y, want.end_y);
                check_field("elapsed_ms", elapsed_ms, want.dur);
                check_field("samples", samples, want.count);
            end
        end
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : run_tests
        rst_n          = 1'b0;
        evt_valid     <= 1'b0;
        req_type      <= KIND_OTHER;
        contact_id    <= '0;
        pos_x         <= '0;
        pos_y         <= '0;
        timestamp     <= '0;
        mismatch_count = 0;
        gap_max        = 9;
        stall_max      = 9;
        hold_request   = 1'b0;
        event_clock    = '0;
        for (int i = 0; i < NUM_SLOTS_DEF; i++)
        begin
            tracked_busy[i]  = 1'b0;
            tracked_owner[i] = '0;
            tracked_x0[i]    = '0;
            tracked_y0[i]    = '0;
            tracked_t0[i]    = '0;
            tracked_count[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_kind();
        test_unmatched_up();
        test_full_gesture();
        test_time_backwards();
        test_repeated_down();
        test_unmatched_move();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(2000);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_summaries.size() != 0)
        begin
            report_mismatch($sformatf("%0d summaries never arrived", pending_summaries.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/tct_pkg.sv
rtl/tct_ram.sv
rtl/tct_div.sv
rtl/touch_contact_tracker.sv
dv/touch_contact_tracker_test.sv
